// File: rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, held off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication in the next cycle, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication in the next cycle, checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/ssfr_pkg.sv
// constants, slot layout tables and shared types of the stream frame receiver
// no dependencies
package ssfr_pkg;

   localparam int PAYLOAD_BYTES = 39;
   localparam int SLOTS         = 16;
   localparam int LAYOUT_LEN    = 16;
   localparam int SLOT_COUNT    = (SLOTS > LAYOUT_LEN) ? LAYOUT_LEN : SLOTS;

   localparam int CNT_W  = 6;
   localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int SLOT_W = $clog2(LAYOUT_LEN);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] START_CODE_RESET = 8'h13;
   localparam logic [7:0] BYTE_ZERO        = 8'h00;
   localparam logic [7:0] BYTE_MASK        = 8'hFF;

   // packet id expected in each slot
   localparam logic [7:0] SLOT_ID [LAYOUT_LEN] = '{
      8'd43, 8'd44, 8'd7,  8'd45, 8'd9,  8'd10, 8'd11, 8'd12,
      8'd21, 8'd23, 8'd56, 8'd22, 8'd26, 8'd35, 8'd18, 8'd25
   };

   // bit i set: slot i carries two data bytes
   localparam logic [LAYOUT_LEN-1:0] SLOT_WIDE = 16'b1001_1110_0000_0011;

   typedef enum logic [1:0] {
      FR_HUNT,
      FR_LENGTH,
      FR_PAYLOAD,
      FR_CHECK
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ID,
      BK_DATA1,
      BK_DATA2,
      BK_PUSH
   } back_state_type;

   typedef struct packed {
      logic frame_ok;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   typedef struct packed {
      logic              frame_ok;
      logic [SLOT_W-1:0] slot;
      logic              id_matched;
      logic [15:0]       value;
      logic              last;
   } result_type;

endpackage

// File: rtl/ssfr_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ssfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 39
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/ssfr_cmd_queue.sv
// short queue of frame commands between front and back parts
// depends on ssfr_pkg
module ssfr_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssfr_pkg::cmd_type     push_cmd,
   output logic                  full,
   input  logic                  pop,
   output ssfr_pkg::cmd_head_type head
);
   import ssfr_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/ssfr_front.sv
// front part: start code hunt, length check, payload store, checksum
// depends on ssfr_pkg; drives the payload ram write port and the command queue
module ssfr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               start_code,
   input  logic                     push,
   input  logic [7:0]               rx_byte,
   output logic                     full,
   input  logic                     cmd_full,
   input  logic                     back_pending,
   output logic                     cmd_push,
   output ssfr_pkg::cmd_type        cmd_out,
   output ssfr_pkg::ram_wr_type     ram_wr
);
   import ssfr_pkg::*;

   front_state_type   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        sum_ff, sum_in;
   logic              accept;
   logic [7:0]        sum_next;

   // payload waits while the back part reads the prior frame, checksum on cmd_full
   assign full     = ((state_ff == FR_PAYLOAD) && back_pending) ||
                     ((state_ff == FR_CHECK) && cmd_full);
   assign accept   = push && !full;
   assign sum_next = sum_ff + rx_byte;

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            FR_HUNT: begin
               if (rx_byte == start_code) begin
                  state_in = FR_LENGTH;
               end
            end
            FR_LENGTH: begin
               state_in = (rx_byte == 8'(PAYLOAD_BYTES)) ? FR_PAYLOAD : FR_HUNT;
            end
            FR_PAYLOAD: begin
               if (count_ff == CNT_W'(PAYLOAD_BYTES - 1)) begin
                  state_in = FR_CHECK;
               end
            end
            FR_CHECK: begin
               state_in = FR_HUNT;
            end
            default: state_in = FR_HUNT;
         endcase
      end
   end

   // outputs and datapath
   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = count_ff[ADDR_W-1:0];
      ram_wr.data  = rx_byte;
      cmd_push     = 1'b0;
      cmd_out.frame_ok = (sum_next == BYTE_ZERO);
      if (accept) begin
         unique case (state_ff)
            FR_HUNT: begin
               sum_in   = rx_byte;
               count_in = '0;
            end
            FR_LENGTH: begin
               sum_in   = sum_next;
               count_in = '0;
            end
            FR_PAYLOAD: begin
               ram_wr.en = 1'b1;
               sum_in    = sum_next;
               count_in  = count_ff + 1'b1;
            end
            FR_CHECK: begin
               sum_in   = sum_next;
               count_in = '0;
               cmd_push = 1'b1;
            end
            default: count_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_HUNT;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// File: rtl/ssfr_back.sv
// back part: walks the slot layout over the payload ram, queues results
// depends on ssfr_pkg; reads the payload ram and the command queue
module ssfr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ssfr_pkg::cmd_head_type     cmd_head,
   output logic                       cmd_pop,
   output logic                       ram_rd_en,
   output logic [ssfr_pkg::ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]                 ram_rd_data,
   output ssfr_pkg::back_status_type  status,
   output logic                       res_empty,
   input  logic                       res_pop,
   output ssfr_pkg::result_type       res_head
);
   import ssfr_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  off_ff, off_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        hi_ff, hi_in;
   logic              in_range_ff, in_range_in;
   logic [7:0]        rd_byte;
   logic              off_in_range;
   logic              is_wide;
   logic              is_last;

   // result queue
   result_type        res_q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] res_wr_ff, res_wr_in;
   logic [QPTR_W-1:0] res_rd_ff, res_rd_in;
   logic [QCNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic              res_full;
   logic              res_push;
   logic              res_take;
   result_type        res_new;

   assign off_in_range = (off_ff < CNT_W'(PAYLOAD_BYTES));
   assign rd_byte      = in_range_ff ? ram_rd_data : BYTE_ZERO;
   assign is_wide      = SLOT_WIDE[slot_ff];
   assign is_last      = (slot_ff == SLOT_W'(SLOT_COUNT - 1));
   assign status.busy  = (state_ff != BK_IDLE);

   assign res_full  = (res_cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign res_empty = (res_cnt_ff == '0);
   assign res_take  = res_pop && !res_empty;
   assign res_head  = res_q_ff[res_rd_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_head.valid && cmd_head.cmd.frame_ok) begin
               state_in = BK_ID;
            end
         end
         BK_ID:    state_in = BK_DATA1;
         BK_DATA1: state_in = is_wide ? BK_DATA2 : BK_PUSH;
         BK_DATA2: state_in = BK_PUSH;
         BK_PUSH: begin
            if (!res_full) begin
               state_in = is_last ? BK_IDLE : BK_ID;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      off_in      = off_ff;
      slot_in     = slot_ff;
      id_in       = id_ff;
      hi_in       = hi_ff;
      in_range_in = in_range_ff;
      cmd_pop     = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = off_ff[ADDR_W-1:0];
      res_push    = 1'b0;
      res_new.frame_ok   = 1'b1;
      res_new.slot       = slot_ff;
      res_new.id_matched = (id_ff == SLOT_ID[slot_ff]);
      res_new.value      = is_wide ? {hi_ff, rd_byte} : {BYTE_ZERO, rd_byte};
      res_new.last       = is_last;
      unique case (state_ff) inside
         BK_IDLE: begin
            off_in  = '0;
            slot_in = '0;
            if (cmd_head.valid) begin
               if (cmd_head.cmd.frame_ok) begin
                  cmd_pop = 1'b1;
               end else if (!res_full) begin
                  // bad checksum: one error result
                  cmd_pop  = 1'b1;
                  res_push = 1'b1;
                  res_new.frame_ok   = 1'b0;
                  res_new.slot       = '0;
                  res_new.id_matched = 1'b0;
                  res_new.value      = '0;
                  res_new.last       = 1'b1;
               end
            end
         end
         BK_ID, BK_DATA1, BK_DATA2: begin
            ram_rd_en   = off_in_range;
            in_range_in = off_in_range;
            off_in      = off_ff + 1'b1;
            if (state_ff == BK_DATA1) begin
               id_in = rd_byte;
            end
            if (state_ff == BK_DATA2) begin
               hi_in = rd_byte;
            end
         end
         BK_PUSH: begin
            if (!res_full) begin
               res_push = 1'b1;
               slot_in  = slot_ff + 1'b1;
            end
         end
         default: off_in = '0;
      endcase
   end

   always_comb begin
      res_wr_in  = res_wr_ff;
      res_rd_in  = res_rd_ff;
      res_cnt_in = res_cnt_ff;
      if (res_push) begin
         res_wr_in = (res_wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_wr_ff + 1'b1;
      end
      if (res_take) begin
         res_rd_in = (res_rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_rd_ff + 1'b1;
      end
      if (res_push && !res_take) begin
         res_cnt_in = res_cnt_ff + 1'b1;
      end else if (res_take && !res_push) begin
         res_cnt_in = res_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         res_wr_ff  <= '0;
         res_rd_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         res_wr_ff  <= res_wr_in;
         res_rd_ff  <= res_rd_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      slot_ff     <= slot_in;
      id_ff       <= id_in;
      hi_ff       <= hi_in;
      in_range_ff <= in_range_in;
      if (res_push) begin
         res_q_ff[res_wr_ff] <= res_new;
      end
   end

endmodule

// File: rtl/sensor_stream_frame_receiver.sv
// top level of the sensor stream frame receiver
// depends on ssfr_pkg, ssfr_ram, ssfr_cmd_queue, ssfr_front, ssfr_back
//
//   channel   direction  handshake              payload
//   req_      in         push / full            rx_byte
//   rsp_      out        pop / empty            frame_ok, slot, id_matched, value, last
//   csr_      in         valid / ready          start_code
//
// one byte is taken per cycle, while full is low, when hunting or storing payload
// a good frame yields one result per slot, stepping BK_ID, BK_DATA1, BK_DATA2 (wide
// slots only) and BK_PUSH, each byte read through the single read port of the ram
// payload bytes of the next frame stall (full high) until the back part has read out
// the previous frame; start and length bytes are still taken meanwhile
// reset is synchronous and clears control state; the start code returns to 19
module sensor_stream_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_frame_ok,
   output logic [3:0]  rsp_slot,
   output logic        rsp_id_matched,
   output logic [15:0] rsp_value,
   output logic        rsp_last,
   // start code register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_start_code
);
   import ssfr_pkg::*;

   logic [7:0]        start_code_ff, start_code_in;
   ram_wr_type        ram_wr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              cmd_push;
   cmd_type           cmd_in;
   logic              cmd_full;
   logic              cmd_pop;
   cmd_head_type      cmd_head;
   back_status_type   back_status;
   logic              back_pending;
   result_type        res_head;

   // every transfer is taken; user writes only while the block is idle, not enforced
   assign csr_ready     = 1'b1;
   assign start_code_in = (csr_valid && csr_ready) ? csr_start_code : start_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
      end else begin
         start_code_ff <= start_code_in;
      end
   end

   // the back part owns the ram while a command waits or a frame is being read
   assign back_pending = back_status.busy || cmd_head.valid;

   ssfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start_code   (start_code_ff),
      .push         (req_push),
      .rx_byte      (req_rx_byte),
      .full         (req_full),
      .cmd_full     (cmd_full),
      .back_pending (back_pending),
      .cmd_push     (cmd_push),
      .cmd_out      (cmd_in),
      .ram_wr       (ram_wr)
   );

   // payload store, written by the front part, read by the back part
   ssfr_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // good or bad frame verdicts, front to back
   ssfr_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .head     (cmd_head)
   );

   ssfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .status      (back_status),
      .res_empty   (rsp_empty),
      .res_pop     (rsp_pop),
      .res_head    (res_head)
   );

   // result fields straight from the head of the result queue
   assign rsp_frame_ok   = res_head.frame_ok;
   assign rsp_slot       = 4'(res_head.slot);
   assign rsp_id_matched = res_head.id_matched;
   assign rsp_value      = res_head.value;
   assign rsp_last       = res_head.last;

endmodule

// File: rtl/ssfr_checker.sv
// port level checks of the sensor stream frame receiver, bound to the top level
// depends on ssfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_frame_ok,
   input logic [3:0]  rsp_slot,
   input logic        rsp_id_matched,
   input logic [15:0] rsp_value,
   input logic        rsp_last
);
   import ssfr_pkg::*;

   // no result is left over from before reset
   `ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, rsp_empty)

   // an error result is a single transfer, last set and all other fields zero
   `ASSERT_SAME(a_error_shape, clock, reset, !rsp_empty && !rsp_frame_ok,
      rsp_last && !rsp_id_matched && (rsp_slot == 4'd0) && (rsp_value == 16'd0))

   // a good frame ends exactly on its final slot
   `ASSERT_SAME(a_last_slot, clock, reset, !rsp_empty && rsp_frame_ok,
      rsp_last == (rsp_slot == 4'(SLOT_COUNT - 1)))

   // a waiting result keeps its value, slot and last flag until popped
   `ASSERT_NEXT(a_result_held, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_value) && $stable(rsp_slot) && $stable(rsp_last))

endmodule

bind sensor_stream_frame_receiver ssfr_checker u_ssfr_checker (.*);

// File: tb/sv/sensor_stream_frame_receiver_test.sv
// self-checking testbench for the sensor stream frame receiver
// depends on ssfr_pkg and sensor_stream_frame_receiver; predicts every result in-line
// and compares each popped result against the oldest predicted slot report
module sensor_stream_frame_receiver_test;
   import ssfr_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   // a full good frame drains more slowly under receiver stalls
   localparam int SETTLE_CYCLES = 100;
   // frame and length bytes per random phase, four phases in all
   localparam int PHASE_BYTES   = 36;
   localparam int LAYOUT_SLOTS  = 16;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 3;
   localparam logic [7:0] DEFAULT_START_CODE = 8'd19;
   localparam int NO_CODE_SWAP  = -1;

   // sensor layout: packet id per slot, and which slots carry two data bytes
   localparam logic [7:0] SENSOR_ID [LAYOUT_SLOTS] = '{
      8'd43, 8'd44, 8'd7,  8'd45, 8'd9,  8'd10, 8'd11, 8'd12,
      8'd21, 8'd23, 8'd56, 8'd22, 8'd26, 8'd35, 8'd18, 8'd25
   };
   localparam logic [LAYOUT_SLOTS-1:0] SENSOR_WIDE = 16'b1001_1110_0000_0011;

   typedef enum int {
      PL_RANDOM,
      PL_ONES,
      PL_ZERO
   } payload_kind_type;

   typedef struct {
      logic        frame_ok;
      logic [3:0]  slot;
      logic        id_matched;
      logic [15:0] value;
      logic        last;
   } slot_report_type;

   // dut ports, all inputs known from time zero
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_push       = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte    = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop        = 1'b0;
   logic        rsp_frame_ok;
   logic [3:0]  rsp_slot;
   logic        rsp_id_matched;
   logic [15:0] rsp_value;
   logic        rsp_last;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_start_code = 8'h00;

   // traffic shaping, percent of cycles spent idle or stalled
   int push_idle_pct = 0;
   int pop_stall_pct = 0;
   int fail_count    = 0;

   // expected results, oldest first
   slot_report_type report_queue[$];

   // predictor copy of the receiver state
   front_state_type rx_phase      = FR_HUNT;
   logic [5:0]      rx_count      = '0;
   logic [7:0]      rx_sum        = '0;
   logic [7:0]      rx_store [PAYLOAD_BYTES];
   logic [7:0]      rx_start_code = DEFAULT_START_CODE;

   // payload of the next frame to send
   logic [7:0] frame_bytes [PAYLOAD_BYTES];

   sensor_stream_frame_receiver dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_rx_byte    (req_rx_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_ok   (rsp_frame_ok),
      .rsp_slot       (rsp_slot),
      .rsp_id_matched (rsp_id_matched),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_start_code (csr_start_code)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // payload entries read past the end of the store come back as zero
   function automatic logic [7:0] stored_byte(input int idx);
      return (idx < PAYLOAD_BYTES) ? rx_store[idx] : 8'h00;
   endfunction

   // advance the predicted deframer by one accepted byte, queue what it emits
   task automatic predict_byte(input logic [7:0] b);
      slot_report_type rep;
      logic [7:0]      total;
      int              off;
      case (rx_phase)
         FR_HUNT: begin
            // anything but the start code is dropped
            if (b == rx_start_code) begin
               rx_sum   = b;
               rx_count = '0;
               rx_phase = FR_LENGTH;
            end
         end
         FR_LENGTH: begin
            // a wrong length goes straight back to hunting, no recheck as start
            if (b == 8'(PAYLOAD_BYTES)) begin
               rx_sum   = rx_sum + b;
               rx_count = '0;
               rx_phase = FR_PAYLOAD;
            end else begin
               rx_phase = FR_HUNT;
            end
         end
         FR_PAYLOAD: begin
            if (rx_count < PAYLOAD_BYTES) rx_store[rx_count] = b;
            rx_sum   = rx_sum + b;
            rx_count = rx_count + 6'd1;
            if (rx_count >= PAYLOAD_BYTES) rx_phase = FR_CHECK;
         end
         default: begin
            total    = rx_sum + b;
            rx_sum   = total;
            rx_phase = FR_HUNT;
            rx_count = '0;
            if (total != 8'h00) begin
               // checksum error: one lone error report
               rep = '{1'b0, 4'd0, 1'b0, 16'd0, 1'b1};
               report_queue.push_back(rep);
            end else begin
               off = 0;
               for (int s = 0; s < SLOT_COUNT; s++) begin
                  rep.frame_ok   = 1'b1;
                  rep.slot       = 4'(s);
                  rep.id_matched = (stored_byte(off) == SENSOR_ID[s]);
                  if (SENSOR_WIDE[s]) begin
                     rep.value = {stored_byte(off + 1), stored_byte(off + 2)};
                     off += 3;
                  end else begin
                     rep.value = {8'h00, stored_byte(off + 1)};
                     off += 2;
                  end
                  rep.last = (s + 1 == SLOT_COUNT);
                  report_queue.push_back(rep);
               end
            end
         end
      endcase
   endtask

   // one byte transfer; acceptance is decided at the falling edge where all is settled
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         taken = !req_full;
         if (taken) predict_byte(b);
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_start_code(input logic [7:0] code);
      bit taken;
      csr_valid      <= 1'b1;
      csr_start_code <= code;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid     <= 1'b0;
      rx_start_code = code;
   endtask

   // stop pushing, let every queued result drain, then let the back end settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (report_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // data byte with extra weight on the two extremes
   function automatic logic [7:0] data_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // lay out id and data bytes slot by slot into the frame buffer
   task automatic fill_payload(input payload_kind_type kind);
      int off;
      int width;
      off = 0;
      for (int s = 0; s < LAYOUT_SLOTS; s++) begin
         width = SENSOR_WIDE[s] ? 2 : 1;
         case (kind)
            PL_ONES: frame_bytes[off] = SENSOR_ID[s];
            PL_ZERO: frame_bytes[off] = 8'h00;
            default: begin
               // mostly the right id, now and then a stray one
               frame_bytes[off] = ($urandom_range(4) != 0) ? SENSOR_ID[s]
                                                           : 8'($urandom_range(255));
            end
         endcase
         for (int d = 1; d <= width; d++) begin
            case (kind)
               PL_ONES: frame_bytes[off + d] = 8'hFF;
               PL_ZERO: frame_bytes[off + d] = 8'h00;
               default: frame_bytes[off + d] = data_byte();
            endcase
         end
         off += width + 1;
      end
   endtask

   // start, length, payload, checksum; optionally rewrite the start code mid payload
   task automatic send_frame(input bit bad_sum, input int swap_at, input logic [7:0] swap_code);
      logic [7:0] sum;
      logic [7:0] check;
      sum = rx_start_code + 8'(PAYLOAD_BYTES);
      send_byte(rx_start_code);
      send_byte(8'(PAYLOAD_BYTES));
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         if (i == swap_at) begin
            wait_idle();
            write_start_code(swap_code);
         end
         send_byte(frame_bytes[i]);
         sum = sum + frame_bytes[i];
      end
      check = 8'h00 - sum;
      if (bad_sum) check = check + 8'($urandom_range(255, 1));
      send_byte(check);
   endtask

   // byte that is surely not the current start code
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == rx_start_code) b = b ^ 8'h80;
      return b;
   endfunction

   // result side: random stalls, check on the falling edge before the pop edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      slot_report_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (report_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual ok=%0d slot=%0d value=%0h",
                     $time, rsp_frame_ok, rsp_slot, rsp_value);
            fail_count++;
         end else begin
            want = report_queue.pop_front();
            check_field("frame_ok", want.frame_ok, rsp_frame_ok);
            check_field("slot", want.slot, rsp_slot);
            check_field("id_matched", want.id_matched, rsp_id_matched);
            check_field("value", want.value, rsp_value);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // reset start code, ignored noise while hunting, then a frame of all-ones data
   task automatic test_default_code_frame();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);
      fill_payload(PL_ONES);
      send_frame(1'b0, NO_CODE_SWAP, 8'h00);
   endtask

   // all-zero payload: every id mismatches, every value zero
   task automatic test_data_extremes();
      fill_payload(PL_ZERO);
      send_frame(1'b0, NO_CODE_SWAP, 8'h00);
   endtask

   task automatic test_bad_checksum();
      fill_payload(PL_RANDOM);
      send_frame(1'b1, NO_CODE_SWAP, 8'h00);
   endtask

   // length off by one either way, and a repeated start code taken as a bad length
   task automatic test_wrong_length();
      send_byte(rx_start_code);
      send_byte(8'(PAYLOAD_BYTES - 1));
      send_byte(rx_start_code);
      send_byte(8'(PAYLOAD_BYTES + 1));
      send_byte(rx_start_code);
      send_byte(rx_start_code);
      send_byte(8'(PAYLOAD_BYTES));
      fill_payload(PL_RANDOM);
      send_frame(1'b0, NO_CODE_SWAP, 8'h00);
   endtask

   // new start code written while a frame is partly received; the frame keeps the old one
   task automatic test_code_change_mid_frame();
      wait_idle();
      fill_payload(PL_RANDOM);
      send_frame(1'b0, 12, 8'hA5);
      fill_payload(PL_RANDOM);
      send_frame(1'b0, NO_CODE_SWAP, 8'h00);
   endtask

   // mostly good frames with random content, plus bad sums, bad lengths and noise
   task automatic test_random_traffic(input logic [7:0] code, input int idle_pct,
                                      input int stall_pct);
      int         budget;
      int         pick;
      logic [7:0] len;
      wait_idle();
      write_start_code(code);
      push_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      budget = 0;
      while (budget < PHASE_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            fill_payload(PL_RANDOM);
            send_frame(1'b0, NO_CODE_SWAP, 8'h00);
            budget += FRAME_BYTES;
         end else if (pick < 78) begin
            fill_payload(PL_RANDOM);
            send_frame(1'b1, NO_CODE_SWAP, 8'h00);
            budget += FRAME_BYTES;
         end else if (pick < 90) begin
            len = 8'($urandom_range(255));
            if (len == 8'(PAYLOAD_BYTES)) len = len ^ (8'h01 << $urandom_range(7));
            send_byte(rx_start_code);
            send_byte(len);
            budget += 2;
         end else begin
            repeat ($urandom_range(4, 1)) send_byte(noise_byte());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) rx_store[i] = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_default_code_frame();
      test_data_extremes();
      test_bad_checksum();
      test_wrong_length();
      test_code_change_mid_frame();

      // start code extremes, the length value itself as start code, one random code
      test_random_traffic(8'hFF, 0, 0);
      test_random_traffic(8'h00, 69, 0);
      test_random_traffic(8'($urandom_range(254, 1)), 0, 69);
      test_random_traffic(8'(PAYLOAD_BYTES), 38, 38);

      wait_idle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog far beyond the slowest correct run
   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/ssfr_pkg.sv
rtl/ssfr_ram.sv
rtl/ssfr_cmd_queue.sv
rtl/ssfr_front.sv
rtl/ssfr_back.sv
rtl/sensor_stream_frame_receiver.sv
rtl/ssfr_checker.sv
tb/sv/sensor_stream_frame_receiver_test.sv
